>>> rtl/sbcs_pkg.sv
package sbcs_pkg;

    // Timer width and saturation value
    localparam int TIMER_WIDTH = 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_MAX     = 3'd4;

    // Register reset values
    localparam logic [15:0] LONG_PRESS_RST   = 16'd500;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0] REPEAT_RST       = 16'd20;
    localparam logic [6:0]  YEAR_MIN_RST     = 7'd20;
    localparam logic [6:0]  YEAR_MAX_RST     = 7'd30;

    // Field limits
    localparam logic [5:0] HOUR_LIMIT   = 6'd23;
    localparam logic [6:0] MINSEC_LIMIT = 7'd59;
    localparam logic [4:0] MONTH_LIMIT  = 5'd12;

    // Selected field codes
    localparam logic [2:0] FIELD_NONE   = 3'd0;
    localparam logic [2:0] FIELD_HOUR   = 3'd1;
    localparam logic [2:0] FIELD_MINUTE = 3'd2;
    localparam logic [2:0] FIELD_SECOND = 3'd3;
    localparam logic [2:0] FIELD_DAY    = 3'd4;
    localparam logic [2:0] FIELD_MONTH  = 3'd5;
    localparam logic [2:0] FIELD_YEAR   = 3'd6;

    // Press kind codes
    localparam logic [1:0] PRESS_NONE  = 2'd0;
    localparam logic [1:0] PRESS_SHORT = 2'd1;
    localparam logic [1:0] PRESS_LONG  = 2'd2;

    // Days in a month; February leap when the year is a multiple of four
    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic [6:0] year);
        logic [4:0] days;
        case (month)
            4'd2:                      days = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

    // Saturating timer increment
    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] t);
        return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

endpackage

>>> rtl/single_button_clock_setter_top.sv
// An accepted request's result is written into the output register at the clock edge that accepts it.
// Throughput: one request per cycle; the input is taken whenever the output
// register is empty or being drained in the same cycle.
// Reset (aresetn, synchronous, active low): press state, timers and field
// selection clear, registers return to their defaults, the output is empty.
module single_button_clock_setter_top
    import sbcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_button_down,
    input  logic [4:0]            s_hour_in,
    input  logic [5:0]            s_minute_in,
    input  logic [5:0]            s_second_in,
    input  logic [4:0]            s_day_in,
    input  logic [3:0]            s_month_in,
    input  logic [6:0]            s_year_in,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_write_clock,
    output logic [4:0]            m_hour_out,
    output logic [5:0]            m_minute_out,
    output logic [5:0]            m_second_out,
    output logic [4:0]            m_day_out,
    output logic [3:0]            m_month_out,
    output logic [6:0]            m_year_out,
    output logic [2:0]            m_field_selected,
    output logic [1:0]            m_press_kind
);

    // configuration registers
    logic [15:0] long_press_reg;
    logic [15:0] idle_timeout_reg;
    logic [15:0] repeat_reg;
    logic [6:0]  year_min_reg;
    logic [6:0]  year_max_reg;

    // press state
    logic                   button_prev_reg, button_prev_next;
    logic                   classifying_reg, classifying_next;
    logic                   held_long_reg, held_long_next;
    logic [TIMER_WIDTH-1:0] press_timer_reg, press_timer_next;
    logic [TIMER_WIDTH-1:0] repeat_timer_reg, repeat_timer_next;
    logic [TIMER_WIDTH-1:0] idle_timer_reg, idle_timer_next;
    logic [2:0]             selected_reg, selected_next;

    // output register
    logic       m_valid_reg;
    logic       write_clock_reg, write_clock_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [4:0] day_reg, day_next;
    logic [3:0] month_reg, month_next;
    logic [6:0] year_reg, year_next;
    logic [1:0] kind_reg, kind_next;

    logic s_fire;
    logic inc;
    logic [TIMER_WIDTH-1:0] press_inc, repeat_inc;
    logic [5:0] hour_p1;
    logic [6:0] minute_p1, second_p1;
    logic [5:0] day_p1;
    logic [4:0] month_p1;
    logic [7:0] year_p1;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg   <= LONG_PRESS_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            repeat_reg       <= REPEAT_RST;
            year_min_reg     <= YEAR_MIN_RST;
            year_max_reg     <= YEAR_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LONG_PRESS:   long_press_reg   <= cfg_wdata[15:0];
                REG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_wdata[15:0];
                REG_REPEAT:       repeat_reg       <= cfg_wdata[15:0];
                REG_YEAR_MIN:     year_min_reg     <= cfg_wdata[6:0];
                REG_YEAR_MAX:     year_max_reg     <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign press_inc  = sat_inc(press_timer_reg);
    assign repeat_inc = sat_inc(repeat_timer_reg);

    // Classify presses and time repeats
    always_comb begin
        classifying_next  = classifying_reg;
        held_long_next    = held_long_reg;
        press_timer_next  = press_timer_reg;
        repeat_timer_next = repeat_timer_reg;
        selected_next     = selected_reg;
        kind_next         = PRESS_NONE;
        inc               = 1'b0;

        if (classifying_reg) begin
            if (!s_button_down) begin
                classifying_next = 1'b0;
                kind_next        = PRESS_SHORT;
                selected_next    = (selected_reg >= FIELD_YEAR) ? FIELD_HOUR
                                                                : selected_reg + 1'b1;
            end else begin
                press_timer_next = press_inc;
                if (32'(press_inc) >= 32'(long_press_reg)) begin
                    classifying_next  = 1'b0;
                    held_long_next    = 1'b1;
                    repeat_timer_next = '0;
                    kind_next         = PRESS_LONG;
                    inc               = 1'b1;
                end
            end
        end else if (held_long_reg) begin
            if (s_button_down) begin
                repeat_timer_next = repeat_inc;
                if (32'(repeat_inc) >= 32'(repeat_reg)) begin
                    repeat_timer_next = '0;
                    inc               = 1'b1;
                end
            end else begin
                held_long_next = 1'b0;
            end
        end else if (s_button_down && !button_prev_reg) begin
            classifying_next = 1'b1;
            press_timer_next = '0;
        end

        // Count released ticks, drop out of set mode after the timeout
        idle_timer_next = s_button_down ? '0 : sat_inc(idle_timer_reg);
        if (32'(idle_timer_next) > 32'(idle_timeout_reg)) begin
            selected_next = FIELD_NONE;
        end
        button_prev_next = s_button_down;
    end

    assign hour_p1   = {1'b0, s_hour_in} + 6'd1;
    assign minute_p1 = {1'b0, s_minute_in} + 7'd1;
    assign second_p1 = {1'b0, s_second_in} + 7'd1;
    assign day_p1    = {1'b0, s_day_in} + 6'd1;
    assign month_p1  = {1'b0, s_month_in} + 5'd1;
    assign year_p1   = {1'b0, s_year_in} + 8'd1;

    // Increment the selected clock field with wrap
    always_comb begin
        hour_next        = s_hour_in;
        minute_next      = s_minute_in;
        second_next      = s_second_in;
        day_next         = s_day_in;
        month_next       = s_month_in;
        year_next        = s_year_in;
        write_clock_next = inc;
        if (inc) begin
            case (selected_reg)
                FIELD_HOUR:   hour_next   = (hour_p1 > HOUR_LIMIT) ? 5'd0 : hour_p1[4:0];
                FIELD_MINUTE: minute_next = (minute_p1 > MINSEC_LIMIT) ? 6'd0
                                                                       : minute_p1[5:0];
                FIELD_SECOND: second_next = (second_p1 > MINSEC_LIMIT) ? 6'd0
                                                                       : second_p1[5:0];
                FIELD_DAY:    day_next    = (day_p1 > {1'b0, days_in_month(s_month_in,
                                                                           s_year_in)})
                                            ? 5'd1 : day_p1[4:0];
                FIELD_MONTH:  month_next  = (month_p1 > MONTH_LIMIT) ? 4'd1 : month_p1[3:0];
                FIELD_YEAR:   year_next   = (year_p1 > {1'b0, year_max_reg}) ? year_min_reg
                                                                             : year_p1[6:0];
                default: ;
            endcase
        end
    end

    // Advance press state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_prev_reg  <= 1'b0;
            classifying_reg  <= 1'b0;
            held_long_reg    <= 1'b0;
            press_timer_reg  <= '0;
            repeat_timer_reg <= '0;
            idle_timer_reg   <= '0;
            selected_reg     <= FIELD_NONE;
        end else if (s_fire) begin
            button_prev_reg  <= button_prev_next;
            classifying_reg  <= classifying_next;
            held_long_reg    <= held_long_next;
            press_timer_reg  <= press_timer_next;
            repeat_timer_reg <= repeat_timer_next;
            idle_timer_reg   <= idle_timer_next;
            selected_reg     <= selected_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            write_clock_reg <= write_clock_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            day_reg         <= day_next;
            month_reg       <= month_next;
            year_reg        <= year_next;
            kind_reg        <= kind_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_write_clock    = write_clock_reg;
    assign m_hour_out       = hour_reg;
    assign m_minute_out     = minute_reg;
    assign m_second_out     = second_reg;
    assign m_day_out        = day_reg;
    assign m_month_out      = month_reg;
    assign m_year_out       = year_reg;
    assign m_field_selected = selected_reg;
    assign m_press_kind     = kind_reg;

endmodule
